// ----- rtl/core/lgs_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the life grid unit.
package lgs_pkg;

  // Grid store geometry
  localparam int MaxCols = 64;
  localparam int MaxRows = 64;
  localparam int ColW    = $clog2(MaxCols);
  localparam int RowW    = $clog2(MaxRows);
  // Sweep counter runs up to the row count plus two
  localparam int CntW    = $clog2(MaxRows + 2);

  // Field and register widths
  localparam int OpW    = 3;
  localparam int SizeW  = 7;
  localparam int AddrW  = 3;
  localparam int DataW  = 32;

  localparam logic [SizeW-1:0] WidthRst  = 7'd64;
  localparam logic [SizeW-1:0] HeightRst = 7'd64;

  // B3/S23 neighbor counts
  localparam logic [3:0] BirthCount   = 4'd3;
  localparam logic [3:0] SurviveCount = 4'd2;

  typedef enum logic [OpW-1:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_ADVANCE = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_FILL    = 3'd4
  } op_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  // Source of the row written back to the store
  typedef enum logic [1:0] {
    WR_CELL = 2'd0,
    WR_SET  = 2'd1,
    WR_LIFE = 2'd2
  } wr_kind_e;

  typedef struct packed {
    logic            load;
    logic            rd_en;
    logic            wr_en;
    logic            cell_mode;
    wr_kind_e        wr_kind;
    logic            set_val;
    logic            win_clr;
    logic            win_shift;
    logic            res_set;
    logic            out_load;
    logic [CntW-1:0] cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic in_area;
  } dp_sts_t;

endpackage

// ----- rtl/core/lgs_dp.sv -----
// Datapath: grid store, three-row window, B3/S23 row logic and result register.
module lgs_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lgs_pkg::dp_cmd_t           cmd_i,
  output lgs_pkg::dp_sts_t           sts_o,
  input  logic [lgs_pkg::SizeW-1:0]  used_cols_i,
  input  logic [lgs_pkg::SizeW-1:0]  used_rows_i,
  input  logic [lgs_pkg::RowW-1:0]   row_i,
  input  logic [lgs_pkg::ColW-1:0]   col_i,
  input  logic                       cell_value_i,
  output logic                       read_value_o
);
  import lgs_pkg::*;

  logic [MaxCols-1:0] mem_q [MaxRows];
  logic [MaxRows-1:0] row_vld_q;
  logic [MaxCols-1:0] mem_rd_q;
  logic               rd_ok_q;

  logic [RowW-1:0]    row_q;
  logic [ColW-1:0]    col_q;
  logic               val_q;
  logic [MaxCols-1:0] prev_q, cur_q;
  logic               res_q;
  logic               read_value_q;

  logic [MaxCols-1:0] rdata;
  logic [MaxCols-1:0] col_mask;
  logic [MaxCols+1:0] pe, ce, ne;
  logic [3:0]         nb_cnt [MaxCols];
  logic [MaxCols-1:0] life_row;
  logic [MaxCols-1:0] wr_data;
  logic [RowW-1:0]    rd_addr, wr_addr;
  logic [CntW-1:0]    lag_cnt;

  assign rdata = rd_ok_q ? mem_rd_q : '0;

  always_comb begin
    for (int j = 0; j < MaxCols; j++) begin
      col_mask[j] = (SizeW'(j) < used_cols_i);
    end
  end

  // Pad the masked window with a dead column on each side
  assign pe = {1'b0, prev_q & col_mask, 1'b0};
  assign ce = {1'b0, cur_q & col_mask, 1'b0};
  assign ne = {1'b0, rdata & col_mask, 1'b0};

  always_comb begin
    for (int j = 0; j < MaxCols; j++) begin
      nb_cnt[j] = 4'(pe[j]) + 4'(pe[j+1]) + 4'(pe[j+2]) + 4'(ce[j]) + 4'(ce[j+2])
                + 4'(ne[j]) + 4'(ne[j+1]) + 4'(ne[j+2]);
      life_row[j] = (nb_cnt[j] == BirthCount) || (ce[j+1] && (nb_cnt[j] == SurviveCount));
    end
  end

  // Life writes trail the read pointer by two rows, fill/clear by one
  assign lag_cnt = cmd_i.cnt - ((cmd_i.wr_kind == WR_LIFE) ? CntW'(2) : CntW'(1));
  assign rd_addr = cmd_i.cell_mode ? row_q : cmd_i.cnt[RowW-1:0];
  assign wr_addr = cmd_i.cell_mode ? row_q : lag_cnt[RowW-1:0];

  always_comb begin
    wr_data = rdata;
    unique case (cmd_i.wr_kind)
      WR_CELL: wr_data[col_q] = val_q;
      WR_SET:  wr_data = (rdata & ~col_mask) | (cmd_i.set_val ? col_mask : '0);
      WR_LIFE: wr_data = (cur_q & ~col_mask) | (life_row & col_mask);
      default: wr_data = rdata;
    endcase
  end

  assign sts_o.in_area = (SizeW'(row_q) < used_rows_i) && (SizeW'(col_q) < used_cols_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    mem_rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
      rd_ok_q <= cmd_i.rd_en && row_vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q <= row_i;
      col_q <= col_i;
      val_q <= cell_value_i;
      res_q <= 1'b0;
    end else if (cmd_i.res_set) begin
      res_q <= rdata[col_q] && sts_o.in_area;
    end
    if (cmd_i.win_clr) begin
      prev_q <= '0;
      cur_q  <= '0;
    end else if (cmd_i.win_shift) begin
      prev_q <= cur_q;
      cur_q  <= rdata;
    end
    if (cmd_i.out_load) begin
      read_value_q <= res_q;
    end
  end

  assign read_value_o = read_value_q;

endmodule

// ----- rtl/core/lgs_ctrl.sv -----
// Controller: operation sequencing, row sweep counter and output beat valid.
module lgs_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [lgs_pkg::OpW-1:0]   operation_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  logic [lgs_pkg::SizeW-1:0] used_cols_i,
  input  logic [lgs_pkg::SizeW-1:0] used_rows_i,
  output lgs_pkg::dp_cmd_t          cmd_o,
  input  lgs_pkg::dp_sts_t          sts_i
);
  import lgs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_SWEEP,
    ST_DONE
  } state_e;

  state_e          state_q;
  op_e             op_q;
  logic [CntW-1:0] cnt_q;
  logic            out_vld_q;

  logic accept;
  logic out_free;
  logic sweep_end;
  logic in_sweep;
  logic area_empty;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_sweep   = (state_q == ST_SWEEP);
  assign area_empty = (used_cols_i == '0) || (used_rows_i == '0);
  assign sweep_end  = (op_q == OP_ADVANCE) ? (cnt_q == CntW'(used_rows_i) + CntW'(1))
                                           : (cnt_q == CntW'(used_rows_i));

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.cnt       = cnt_q;
    cmd_o.cell_mode = !in_sweep;
    cmd_o.set_val   = (op_q == OP_FILL);
    cmd_o.wr_kind   = in_sweep ? ((op_q == OP_ADVANCE) ? WR_LIFE : WR_SET) : WR_CELL;
    cmd_o.rd_en     = (state_q == ST_CELL_RD) ||
                      (in_sweep && (cnt_q < CntW'(used_rows_i)));
    cmd_o.wr_en     = ((state_q == ST_CELL_WR) && (op_q == OP_WRITE) && sts_i.in_area) ||
                      (in_sweep && ((op_q == OP_ADVANCE) ? (cnt_q >= CntW'(2))
                                                         : (cnt_q != '0)));
    cmd_o.win_clr   = in_sweep && (cnt_q == '0);
    cmd_o.win_shift = in_sweep && (cnt_q != '0);
    cmd_o.res_set   = (state_q == ST_CELL_WR) && (op_q == OP_READ);
    cmd_o.out_load  = (state_q == ST_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_WRITE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q  <= op_e'(operation_i);
            cnt_q <= '0;
            unique case (op_e'(operation_i))
              OP_WRITE, OP_READ: state_q <= ST_CELL_RD;
              OP_ADVANCE, OP_CLEAR, OP_FILL: state_q <= area_empty ? ST_DONE : ST_SWEEP;
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_CELL_RD: state_q <= ST_CELL_WR;
        ST_CELL_WR: state_q <= ST_DONE;
        ST_SWEEP: begin
          cnt_q <= cnt_q + CntW'(1);
          if (sweep_end) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/life_grid_generation_step_unit.sv -----
// Top level of the life grid unit: register port, controller and datapath.
//
// Holds a grid of up to 64 x 64 one-bit cells and runs one command per input
// beat: write cell, read cell, advance one B3/S23 generation, clear or fill
// the area in use. Every input beat yields exactly one output beat carrying
// read_value (the cell for a read, 0 otherwise).
// Channels: valid/stall on both sides; a beat moves when valid is high and
// stall is low. The unit works on one command at a time and raises
// in_stall_o from acceptance until the result is parked in the output
// register; a waiting result does not block the next command from entering.
// A cell write or read passes through a read state and a write state;
// unused codes go straight to the done state; clear, fill and advance
// sweep the rows of the area in use, and the sweep dominates: one row
// is read and one written per cycle through a row memory with separate read
// and write ports, and a three-row window feeds the neighbor count logic.
// Reset empties every row (per-row valid bits read unwritten rows as dead)
// and sets width and height to 64. If the receiver stalls, the output beat
// holds and the unit waits with its result before taking the next command.
// Width/height registers sit at byte addresses 0 and 4.
module life_grid_generation_step_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [lgs_pkg::OpW-1:0]   operation_i,
  input  logic [lgs_pkg::RowW-1:0]  row_i,
  input  logic [lgs_pkg::ColW-1:0]  col_i,
  input  logic                      cell_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      read_value_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lgs_pkg::AddrW-1:0] paddr,
  input  logic [lgs_pkg::DataW-1:0] pwdata,
  output logic [lgs_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import lgs_pkg::*;

  logic [SizeW-1:0] grid_width_q, grid_height_q;
  logic [SizeW-1:0] used_cols, used_rows;
  logic             cfg_wr;
  reg_idx_e         reg_idx;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  // Register port: zero wait states, write in the access phase
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= WidthRst;
      grid_height_q <= HeightRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIDTH:  grid_width_q  <= pwdata[SizeW-1:0];
        REG_HEIGHT: grid_height_q <= pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_WIDTH:  prdata = DataW'(grid_width_q);
      REG_HEIGHT: prdata = DataW'(grid_height_q);
      default:    prdata = '0;
    endcase
  end

  // Clamp the area in use to the store
  assign used_cols = (grid_width_q > SizeW'(MaxCols)) ? SizeW'(MaxCols) : grid_width_q;
  assign used_rows = (grid_height_q > SizeW'(MaxRows)) ? SizeW'(MaxRows) : grid_height_q;

  lgs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .used_cols_i (used_cols),
    .used_rows_i (used_rows),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lgs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .used_cols_i  (used_cols),
    .used_rows_i  (used_rows),
    .row_i        (row_i),
    .col_i        (col_i),
    .cell_value_i (cell_value_i),
    .read_value_o (read_value_o)
  );

endmodule

// ----- rtl/core/lgs_checker.sv -----
// Port-level assertions for the life grid unit, bound to the top level.
module lgs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  // A stalled output beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // One command at a time: an accepted beat makes the unit busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous command in flight");

  // A new result only appears after a busy period
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a command in flight");

  // Going idle always leaves a result in the output register
  a_idle_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("command finished without a result");

endmodule

bind life_grid_generation_step_unit lgs_checker u_lgs_checker (.*);
